// ===== hw/rtl/rfa_pkg.sv =====
package rfa_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned FracW  = 12;
  localparam int unsigned FitW   = 41;
  // square of a Q4.12 value reaches 2^30, so one more bit than 30
  localparam int unsigned SqW    = 31;
  // 10*(16384-c) stays below 2^19
  localparam int unsigned RomW   = 19;
  localparam int unsigned RomShift = 10;
  localparam int unsigned IncW   = 31;

  localparam logic [63:0] PiQ58  = 64'h3243F6A8885A308D >> 2;
  localparam logic [63:0] OneQ58 = 64'd1 << 58;

  typedef struct packed {
    logic            last;
    logic [IncW-1:0] inc;
  } rfa_work_t;

  // upper bound of the running sum: min(max_dim * 84 * 2^24, 2^41 - 1)
  function automatic logic [FitW-1:0] sat_limit(int unsigned max_dim);
    logic [63:0] lim_raw;
    logic [63:0] width_max;
    lim_raw   = 64'(max_dim) * 64'd84 * 64'd16777216;
    width_max = (64'd1 << FitW) - 64'd1;
    return FitW'((lim_raw < width_max) ? lim_raw : width_max);
  endfunction

endpackage

// ===== hw/rtl/rfa_fifo.sv =====
module rfa_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== hw/rtl/rfa_cos_rom.sv =====
module rfa_cos_rom #(
  parameter int unsigned CosTableSize = 1024
) (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic [$clog2(CosTableSize)-1:0] addr_i,
  output logic [rfa_pkg::RomW-1:0]        data_o
);
  import rfa_pkg::*;

  localparam logic [63:0] ThetaStep = PiQ58 / CosTableSize;

  // 10*(16384 - round(16384*cos(2*pi*k/n))), built at elaboration from a Q58 series
  function automatic logic [RomW-1:0] rom_entry(int unsigned k, int unsigned n,
                                                logic [63:0] step);
    logic        [63:0]  kk;
    logic        [63:0]  theta;
    logic        [63:0]  t2;
    logic        [63:0]  term;
    logic        [63:0]  mag;
    logic        [63:0]  r;
    logic signed [63:0]  sum;
    logic signed [63:0]  c;
    logic signed [63:0]  val;
    logic        [127:0] p;
    int unsigned         i;
    kk    = (k <= n - k) ? 64'(k) : 64'(n - k);
    theta = step * (kk << 1);
    p     = {64'd0, theta} * {64'd0, theta};
    t2    = p[121:58];
    term  = OneQ58;
    sum   = $signed(OneQ58);
    for (i = 1; i <= 30; i++) begin
      p    = {64'd0, term} * {64'd0, t2};
      term = p[121:58] / 64'((2 * i - 1) * (2 * i));
      if (i[0]) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    mag = sum[63] ? 64'(-sum) : 64'(sum);
    r   = (mag + (64'd1 << 43)) >> 44;
    c   = sum[63] ? -$signed(r) : $signed(r);
    val = (64'sd16384 - c) * 64'sd10;
    return RomW'(val);
  endfunction

  logic [RomW-1:0] rom [CosTableSize];
  logic [RomW-1:0] data_q;

  for (genvar g = 0; g < CosTableSize; g++) begin : g_rom
    assign rom[g] = rom_entry(g, CosTableSize, ThetaStep);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= rom[addr_i];
    end
  end

  assign data_o = data_q;

endmodule

// ===== hw/rtl/rfa_front.sv =====
module rfa_front #(
  parameter int unsigned CosTableSize = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [rfa_pkg::CoordW-1:0] coord_i,
  input  logic                       last_i,
  output logic                       full_o,
  output logic                       work_push_o,
  output rfa_pkg::rfa_work_t         work_o,
  input  logic                       work_full_i
);
  import rfa_pkg::*;

  localparam int unsigned IdxW  = $clog2(CosTableSize);
  localparam int unsigned ProdW = FracW + $clog2(CosTableSize + 1);

  logic                advance;
  logic                accept;
  logic [ProdW-1:0]    prod;
  logic [IdxW-1:0]     rom_addr;
  logic [RomW-1:0]     rom_data;
  logic signed [31:0]  coord_ext;
  logic signed [31:0]  sq_full;
  logic                valid_q, valid_d;
  logic [SqW-1:0]      sq_q;
  logic                last_q;

  assign advance = !valid_q || !work_full_i;
  assign accept  = push_i && advance;
  assign full_o  = !advance;

  // fraction of x as a table index: k = (x[11:0] * n) >> 12
  assign prod     = ProdW'(coord_i[FracW-1:0]) * ProdW'(CosTableSize);
  assign rom_addr = prod[FracW +: IdxW];

  assign coord_ext = {{(32 - CoordW){coord_i[CoordW-1]}}, coord_i};
  assign sq_full   = coord_ext * coord_ext;

  rfa_cos_rom #(
    .CosTableSize(CosTableSize)
  ) u_cos_rom (
    .clk_i (clk_i),
    .en_i  (accept),
    .addr_i(rom_addr),
    .data_o(rom_data)
  );

  always_comb begin
    valid_d = valid_q;
    if (advance) begin
      valid_d = accept;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sq_q   <= sq_full[SqW-1:0];
      last_q <= last_i;
    end
  end

  assign work_push_o = valid_q && !work_full_i;
  assign work_o.last = last_q;
  assign work_o.inc  = sq_q + IncW'({rom_data, RomShift'(0)});

endmodule

// ===== hw/rtl/rfa_back.sv =====
module rfa_back #(
  parameter int unsigned MaxDimension = 1024
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     work_empty_i,
  input  rfa_pkg::rfa_work_t       work_i,
  output logic                     work_pop_o,
  output logic                     res_push_o,
  output logic [rfa_pkg::FitW-1:0] res_o,
  input  logic                     res_full_i
);
  import rfa_pkg::*;

  localparam logic [FitW-1:0] Limit = sat_limit(MaxDimension);

  logic [FitW-1:0] sum_q, sum_d;
  logic [FitW:0]   sum_next;
  logic [FitW-1:0] sum_sat;
  logic            take;

  // hold a closing item until the result queue has room
  assign take     = !work_empty_i && (!work_i.last || !res_full_i);
  assign sum_next = {1'b0, sum_q} + (FitW + 1)'(work_i.inc);
  assign sum_sat  = (sum_next > {1'b0, Limit}) ? Limit : sum_next[FitW-1:0];

  assign work_pop_o = take;
  assign res_push_o = take && work_i.last;
  assign res_o      = sum_sat;

  always_comb begin
    sum_d = sum_q;
    if (take) begin
      sum_d = work_i.last ? '0 : sum_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

endmodule

// ===== hw/rtl/rastrigin_fitness_accumulator_top.sv =====
// channel   direction  handshake          payload
// input     in         push / full        coord_i (s16 Q4.12), last_i
// result    out        empty / pop        fitness_o (u41 Q.24)
//
// One item per cycle unless a full queue backs up. The front stage registers x*x
// and the cosine ROM read, a two-entry queue decouples it from the accumulator,
// which adds one item a cycle; results reach fitness_o through the result queue.
// Reset clears the running sum and both queues; the ROM needs no fill.
// A full result queue stalls only the closing item, the input side keeps
// filling until the work queue and front stage back up.
module rastrigin_fitness_accumulator_top #(
  parameter int unsigned MaxDimension = 1024,
  parameter int unsigned CosTableSize = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  output logic                       full,
  input  logic [rfa_pkg::CoordW-1:0] coord_i,
  input  logic                       last_i,
  output logic                       empty,
  input  logic                       pop,
  output logic [rfa_pkg::FitW-1:0]   fitness_o
);
  import rfa_pkg::*;

  localparam logic [FitW-1:0] Limit = sat_limit(MaxDimension);

  logic      work_push, work_full, work_pop, work_empty;
  rfa_work_t work_in, work_out;
  logic      res_push, res_full;
  logic [FitW-1:0] res_data;

  rfa_front #(
    .CosTableSize(CosTableSize)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .coord_i    (coord_i),
    .last_i     (last_i),
    .full_o     (full),
    .work_push_o(work_push),
    .work_o     (work_in),
    .work_full_i(work_full)
  );

  rfa_fifo #(
    .Width($bits(rfa_work_t)),
    .Depth(2)
  ) u_work_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (work_push),
    .wdata_i(work_in),
    .full_o (work_full),
    .pop_i  (work_pop),
    .rdata_o(work_out),
    .empty_o(work_empty)
  );

  rfa_back #(
    .MaxDimension(MaxDimension)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .work_empty_i(work_empty),
    .work_i      (work_out),
    .work_pop_o  (work_pop),
    .res_push_o  (res_push),
    .res_o       (res_data),
    .res_full_i  (res_full)
  );

  rfa_fifo #(
    .Width(FitW),
    .Depth(2)
  ) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .wdata_i(res_data),
    .full_o (res_full),
    .pop_i  (pop),
    .rdata_o(fitness_o),
    .empty_o(empty)
  );

  a_work_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    work_push |-> !work_full)
    else $error("work queue pushed while full");

  a_res_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full)
    else $error("result queue pushed while full");

  a_pop_needs_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    work_pop |-> !work_empty)
    else $error("accumulator took an item from an empty queue");

  a_fitness_saturated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> (res_data <= Limit))
    else $error("result above saturation limit");

endmodule

// ===== dv/testbench.sv =====
module testbench;

  localparam int unsigned MaxDim     = 1024;
  localparam int unsigned CosSize    = 1024;
  localparam int unsigned FitW       = rfa_pkg::FitW;
  localparam int unsigned CoordW     = rfa_pkg::CoordW;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned HoldCycles = 300;

  localparam logic [63:0] PiQ58    = 64'h3243F6A8885A308D >> 2;
  localparam logic [63:0] OneQ58   = 64'd1 << 58;
  localparam logic [63:0] WidthMax = (64'd1 << FitW) - 64'd1;
  localparam logic [63:0] DimLimit = (64'(MaxDim) * 64'd84) << 24;
  localparam logic [63:0] FitLimit = (DimLimit < WidthMax) ? DimLimit : WidthMax;

  logic              clk = 1'b0;
  logic              rst_ni;
  logic              push;
  logic              full;
  logic [CoordW-1:0] coord_i;
  logic              last_i;
  logic              empty;
  logic              pop;
  logic [FitW-1:0]   fitness_o;

  int              cos_table [CosSize];
  logic [63:0]     fitness_sum = '0;
  logic [FitW-1:0] fitness_expected [$];
  int unsigned     error_count = 0;
  int unsigned     quiet_cycles = 0;
  int unsigned     hold_request = 0;
  bit              sender_burst = 1'b0;

  rastrigin_fitness_accumulator_top #(
    .MaxDimension(MaxDim),
    .CosTableSize(CosSize)
  ) dut (
    .clk_i    (clk),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .coord_i  (coord_i),
    .last_i   (last_i),
    .empty    (empty),
    .pop      (pop),
    .fitness_o(fitness_o)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // unsigned Q58 product, bits 58 to 121 of the full 128-bit product
  function automatic logic [63:0] q58_product(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[121:58];
  endfunction

  // round(16384*cos(2*pi*k/CosSize)) by a Q58 Taylor series on [0, pi]
  function automatic int cos_q14(int unsigned k);
    logic [63:0]        kk;
    logic [63:0]        theta;
    logic [63:0]        t2;
    logic [63:0]        term;
    logic [63:0]        mag;
    logic [63:0]        r;
    logic signed [63:0] acc;
    int                 i;
    kk    = (k <= CosSize - k) ? 64'(k) : 64'(CosSize - k);
    theta = (PiQ58 / 64'(CosSize)) * (64'd2 * kk);
    t2    = q58_product(theta, theta);
    term  = OneQ58;
    acc   = $signed(OneQ58);
    for (i = 1; i <= 30; i++) begin
      term = q58_product(term, t2) / (64'(2 * i - 1) * 64'(2 * i));
      if (i % 2 == 1) acc = acc - $signed(term);
      else acc = acc + $signed(term);
    end
    mag = (acc < 0) ? 64'(-acc) : 64'(acc);
    r   = (mag + (64'd1 << 43)) >> 44;
    return (acc < 0) ? -int'(r) : int'(r);
  endfunction

  // fold one coordinate into the running fitness; close the vector on last
  function automatic void accumulate_coord(logic [CoordW-1:0] value, logic is_last);
    longint      x;
    longint      cterm;
    int unsigned k;
    x = longint'($signed(value));
    k = (32'(value[11:0]) * CosSize) >> 12;
    if (k >= CosSize) k = CosSize - 1;
    cterm = 64'sd10 * (64'sd16384 - longint'(cos_table[k])) * 64'sd1024;
    fitness_sum = fitness_sum + 64'(x * x) + 64'(cterm);
    if (fitness_sum > FitLimit) fitness_sum = FitLimit;
    if (is_last) begin
      fitness_expected.push_back(FitW'(fitness_sum));
      fitness_sum = '0;
    end
  endfunction

  task automatic send_coord(input logic [CoordW-1:0] value, input logic is_last);
    int unsigned gap;
    gap = sender_burst ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push    <= 1'b1;
    coord_i <= value;
    last_i  <= is_last;
    @(posedge clk);
    while (full) @(posedge clk);
    accumulate_coord(value, is_last);
  endtask

  // hold the input until every outstanding fitness has been popped
  task automatic wait_drained();
    push <= 1'b0;
    while (fitness_expected.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_extremes();
    sender_burst = 1'b0;
    send_coord(16'h0000, 1'b1);
    send_coord(16'h7FFF, 1'b1);
    send_coord(16'h8000, 1'b1);
    // half-integer points, cosine at -1, both signs
    send_coord(16'h0800, 1'b1);
    send_coord(16'hF800, 1'b1);
    send_coord(16'h0001, 1'b1);
    send_coord(16'hFFFF, 1'b1);
    send_coord(16'h1000, 1'b1);
    send_coord(16'hF000, 1'b1);
    send_coord(16'h1234, 1'b0);
    send_coord(16'hEDCC, 1'b0);
    send_coord(16'h7FFF, 1'b0);
    send_coord(16'h8000, 1'b1);
    // table index edges: first step, inside entry zero, top entry
    send_coord(16'h0004, 1'b0);
    send_coord(16'h0003, 1'b0);
    send_coord(16'h0FFF, 1'b1);
  endtask

  // -7.5 adds nearly the most per item; a vector of this length drives the sum into its clamp
  task automatic test_saturation();
    int unsigned i;
    sender_burst = 1'b1;
    for (i = 0; i < 1140; i++) send_coord(16'h8800, i == 1139);
    send_coord(16'h0000, 1'b1);
    sender_burst = 1'b0;
  endtask

  task automatic test_backpressure();
    int unsigned i;
    hold_request = HoldCycles;
    sender_burst = 1'b1;
    for (i = 0; i < 40; i++) send_coord(16'($urandom()), ($urandom_range(0, 2) != 0));
    send_coord(16'($urandom()), 1'b1);
    sender_burst = 1'b0;
    wait_drained();
  endtask

  task automatic test_random_vectors();
    int unsigned       sent;
    int unsigned       len;
    int unsigned       i;
    logic [CoordW-1:0] value;
    sent = 0;
    while (sent < 300) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      sender_burst = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 19) == 0) wait_drained();
      for (i = 0; i < len; i++) begin
        value = 16'($urandom());
        case ($urandom_range(0, 5))
          0: value[11:0] = 12'h000;
          1: value[11:0] = 12'h800;
          2: value[11:0] = 12'hFFF;
          3: value = ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
          default: ;
        endcase
        send_coord(value, i == len - 1);
      end
      sent += len;
    end
    sender_burst = 1'b0;
  endtask

  // result side: check each popped fitness, idle or hold between pops
  initial begin
    int unsigned     result_gap;
    int unsigned     hold_left;
    bit              receiver_burst;
    logic [FitW-1:0] want;
    result_gap     = 0;
    hold_left      = 0;
    receiver_burst = 1'b0;
    pop            = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk);
      if (pop && !empty) begin
        if (fitness_expected.size() == 0) begin
          $error("fitness: none expected, got %0d", fitness_o);
          error_count++;
        end else begin
          want = fitness_expected.pop_front();
          if (fitness_o !== want) begin
            $error("fitness: expected %0d, got %0d", want, fitness_o);
            error_count++;
          end
        end
        if ($urandom_range(0, 31) == 0) receiver_burst = !receiver_burst;
        result_gap = receiver_burst ? 0 : $urandom_range(0, 5);
      end
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (result_gap != 0) begin
        result_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_ni === 1'b1) begin
      if ((push && !full) || (pop && !empty)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    int unsigned k;
    push    = 1'b0;
    coord_i = '0;
    last_i  = 1'b0;
    rst_ni  = 1'b0;
    for (k = 0; k < CosSize; k++) cos_table[k] = cos_q14(k);
    repeat (11) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);
    test_directed_extremes();
    wait_drained();
    test_saturation();
    wait_drained();
    test_backpressure();
    test_random_vectors();
    wait_drained();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/rfa_pkg.sv
hw/rtl/rfa_fifo.sv
hw/rtl/rfa_cos_rom.sv
hw/rtl/rfa_front.sv
hw/rtl/rfa_back.sv
hw/rtl/rastrigin_fitness_accumulator_top.sv
dv/testbench.sv
